// ===== rtl/tspat_pkg.sv =====
package tspat_pkg;

   localparam int PID_W = 13;
   localparam int CNT_W = 8;
   localparam int HDR_W = 38;
   localparam int POS_W = 12;

   localparam logic [12:0] NIT_PID_RESET = 13'h0010;
   localparam logic [7:0]  PAT_TABLE_ID  = 8'h00;
   localparam logic [11:0] MIN_SECT_LEN  = 12'd9;
   localparam logic [11:0] HEAD_BYTES    = 12'd5;
   localparam logic [11:0] CRC_BYTES     = 12'd4;

   localparam logic [2:0] RSN_NONE     = 3'd0;
   localparam logic [2:0] RSN_TABLE_ID = 3'd1;
   localparam logic [2:0] RSN_SYNTAX   = 3'd2;
   localparam logic [2:0] RSN_ZERO    = 3'd3;
   localparam logic [2:0] RSN_FULL     = 3'd4;

   typedef enum logic [1:0] {
      KIND_ENTRY = 2'd0,
      KIND_DONE  = 2'd1,
      KIND_REJECT = 2'd2,
      KIND_QUERY = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_HEAD = 2'd1,
      PH_BODY = 2'd2
   } phase_type;

   // lookup beat walking down the entry chain
   typedef struct packed {
      logic             valid;
      logic [CNT_W-1:0] remaining;
      logic [PID_W-1:0] pid;
      logic             found;
   } tok_type;

endpackage

// ===== rtl/tspat_cell.sv =====
module tspat_cell
   import tspat_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             shift_en,
   input  logic [PID_W-1:0] pid_prev,
   output logic [PID_W-1:0] pid_next,
   input  tok_type          tok_prev,
   output tok_type          tok_next
);

   logic [PID_W-1:0] pid_ff, pid_in;
   tok_type          tok_ff, tok_in;
   logic             hit;

   assign hit = (tok_prev.remaining != '0) && (pid_ff == tok_prev.pid);

   always_comb begin
      pid_in = shift_en ? pid_prev : pid_ff;
      tok_in = tok_prev;
      tok_in.found = tok_prev.found | hit;
      if (tok_prev.remaining != '0) begin
         tok_in.remaining = tok_prev.remaining - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      pid_ff <= pid_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   assign pid_next = pid_ff;
   assign tok_next = tok_ff;

endmodule

// ===== rtl/ts_pat_section_parser.sv =====
// PAT section parser with a program table held in a chain of entry cells.
// Input channel: drive start high with req_* for one cycle; the beat is
// taken when start is high and busy is low. req_action 0 carries one
// section byte (req_start_of_section marks the table id byte), 1 asks
// whether req_query_pid is held in the program table.
// Result channel: rsp_valid strobes for one cycle with all rsp_* fields;
// the receiver cannot stall, so every result must be taken when shown.
// Section bytes: the result, if any, appears the cycle after the beat and
// busy never rises, so one byte can be taken in every cycle unless a query
// holds busy high. Queries: the lookup beat walks the MAX_PROGRAMS cells
// one per cycle; busy stays high until it leaves the last cell, and the
// answer strobes in the same cycle that busy falls.
// Stored entries enter at the head of the chain and shift one cell along
// on each store.
// Reset: synchronous, active high; parser goes idle, the table is empty,
// the NIT PID returns to 0x0010. Cell contents are not cleared; the
// entry count bounds every lookup.
module ts_pat_section_parser
   import tspat_pkg::*;
#(
   parameter int MAX_PROGRAMS = 64
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_action,
   input  logic [7:0]  req_data_byte,
   input  logic        req_start_of_section,
   input  logic [12:0] req_query_pid,
   output logic        rsp_valid,
   output logic [1:0]  rsp_result_kind,
   output logic [15:0] rsp_program_number,
   output logic [12:0] rsp_pid,
   output logic        rsp_is_pmt,
   output logic [2:0]  rsp_reject_reason,
   output logic        rsp_section_valid,
   output logic [15:0] rsp_stream_id,
   output logic [4:0]  rsp_version,
   output logic        rsp_current_next,
   output logic [7:0]  rsp_section_index,
   output logic [7:0]  rsp_last_section_index,
   output logic [31:0] rsp_crc_word
);

   localparam int CW = $clog2(MAX_PROGRAMS + 1);

   // parser state
   phase_type        phase_ff, phase_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [11:0]      len_ff, len_in;
   logic [HDR_W-1:0] hdr_ff, hdr_in;
   logic [31:0]      ent_ff, ent_in;
   logic [31:0]      crc_ff, crc_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [PID_W-1:0] nit_ff, nit_in;
   logic             busy_ff, busy_in;

   // result registers
   logic        rv_ff, rv_in;
   kind_type    kind_ff, kind_in;
   logic [15:0] prog_ff, prog_in;
   logic [12:0] pid_ff, pid_in;
   logic        pmt_ff, pmt_in;
   logic [2:0]  rsn_ff, rsn_in;
   logic        sv_ff, sv_in;
   logic [15:0] sid_ff, sid_in;
   logic [4:0]  ver_ff, ver_in;
   logic        cn_ff, cn_in;
   logic [7:0]  sec_ff, sec_in;
   logic [7:0]  lsec_ff, lsec_in;
   logic [31:0] crcw_ff, crcw_in;

   logic             accept, byte_acc, qry_acc;
   phase_type        ph_cur;
   logic [POS_W-1:0] pos_cur;
   logic [11:0]      len_cur, leff, ent_end, crc_first;
   logic [HDR_W-1:0] hdr_cur;
   logic [31:0]      ent_cur, crc_cur, ent_new, crc_new;
   logic [7:0]       b;
   logic             in_head, in_body;
   logic             hd_rej, hd_last;
   logic [2:0]       hd_rsn;
   logic             is_hdr, is_ent, ent_fin, is_crc, is_done;
   logic             room, store;
   logic [15:0]      new_prog;
   logic [12:0]      new_pid;

   tok_type          tok_chain [0:MAX_PROGRAMS];
   logic [PID_W-1:0] pid_chain [0:MAX_PROGRAMS-1];
   logic [MAX_PROGRAMS-1:0] tok_vld;

   assign accept   = start & ~busy_ff;
   assign byte_acc = accept & ~req_action;
   assign qry_acc  = accept & req_action;
   assign b        = req_data_byte;

   // a start of section restarts the section state from a clean header
   assign ph_cur  = req_start_of_section ? PH_HEAD : phase_ff;
   assign pos_cur = req_start_of_section ? '0 : pos_ff;
   assign len_cur = req_start_of_section ? '0 : len_ff;
   assign hdr_cur = req_start_of_section ? '0 : hdr_ff;
   assign ent_cur = req_start_of_section ? '0 : ent_ff;
   assign crc_cur = req_start_of_section ? '0 : crc_ff;

   assign in_head = byte_acc && (ph_cur == PH_HEAD);
   assign in_body = byte_acc && (ph_cur == PH_BODY);

   always_comb begin
      hd_rsn = RSN_NONE;
      if (pos_cur == POS_W'(0)) begin
         if (b != PAT_TABLE_ID) hd_rsn = RSN_TABLE_ID;
      end else if (pos_cur == POS_W'(1)) begin
         if (!b[7]) hd_rsn = RSN_SYNTAX;
         else if (b[6]) hd_rsn = RSN_ZERO;
      end
   end
   assign hd_rej  = in_head && (hd_rsn != RSN_NONE);
   assign hd_last = in_head && (pos_cur != POS_W'(0)) && (pos_cur != POS_W'(1));

   // body layout: five header bytes, whole entries, skipped remainder, crc
   assign leff      = (len_cur < MIN_SECT_LEN) ? MIN_SECT_LEN : len_cur;
   assign ent_end   = HEAD_BYTES + ((leff - MIN_SECT_LEN) & ~12'd3);
   assign crc_first = leff - CRC_BYTES;

   assign is_hdr  = in_body && (pos_cur < HEAD_BYTES);
   assign is_ent  = in_body && !is_hdr && (pos_cur < ent_end);
   assign ent_fin = is_ent && (pos_cur[1:0] == 2'd0);
   assign is_crc  = in_body && !is_hdr && !is_ent && (pos_cur >= crc_first);
   assign is_done = is_crc && (pos_cur == leff - 12'd1);

   assign ent_new  = {ent_cur[23:0], b};
   assign crc_new  = {crc_cur[23:0], b};
   assign new_prog = ent_new[31:16];
   assign new_pid  = ent_new[12:0];
   assign room     = cnt_ff < CW'(MAX_PROGRAMS);
   assign store    = ent_fin && room;

   // next state
   always_comb begin
      phase_in = phase_ff;
      if (byte_acc) begin
         phase_in = ph_cur;
         if (hd_rej || is_done) phase_in = PH_IDLE;
         else if (hd_last) phase_in = PH_BODY;
      end
   end

   // datapath and results
   always_comb begin
      pos_in  = pos_ff;
      len_in  = len_ff;
      hdr_in  = hdr_ff;
      ent_in  = ent_ff;
      crc_in  = crc_ff;
      cnt_in  = cnt_ff;
      nit_in  = nit_ff;
      busy_in = busy_ff;

      rv_in   = 1'b0;
      kind_in = KIND_ENTRY;
      prog_in = '0;
      pid_in  = '0;
      pmt_in  = 1'b0;
      rsn_in  = RSN_NONE;
      sv_in   = 1'b0;
      sid_in  = '0;
      ver_in  = '0;
      cn_in   = 1'b0;
      sec_in  = '0;
      lsec_in = '0;
      crcw_in = '0;

      if (byte_acc) begin
         pos_in = pos_cur;
         len_in = len_cur;
         hdr_in = hdr_cur;
         ent_in = ent_cur;
         crc_in = crc_cur;
      end

      if (in_head) begin
         if (hd_rej) begin
            rv_in   = 1'b1;
            kind_in = KIND_REJECT;
            rsn_in  = hd_rsn;
         end else if (pos_cur == POS_W'(0)) begin
            pos_in = POS_W'(1);
         end else if (pos_cur == POS_W'(1)) begin
            len_in = {b[3:0], 8'h00};
            pos_in = POS_W'(2);
         end else begin
            len_in = len_cur | {4'h0, b};
            pos_in = '0;
         end
      end

      if (in_body) begin
         pos_in = pos_cur + POS_W'(1);
      end
      if (is_hdr) begin
         if (pos_cur == POS_W'(2)) hdr_in = {hdr_cur[HDR_W-7:0], b[5:0]};
         else hdr_in = {hdr_cur[HDR_W-9:0], b};
      end
      if (is_ent) begin
         ent_in = ent_new;
      end
      if (ent_fin) begin
         rv_in   = 1'b1;
         kind_in = KIND_ENTRY;
         prog_in = new_prog;
         pid_in  = new_pid;
         if (room) cnt_in = cnt_ff + CW'(1);
         else rsn_in = RSN_FULL;
         if (new_prog == 16'h0000) nit_in = new_pid;
      end
      if (is_crc) begin
         crc_in = crc_new;
      end
      if (is_done) begin
         rv_in   = 1'b1;
         kind_in = KIND_DONE;
         pid_in  = nit_ff;
         sv_in   = (len_cur[11:10] == 2'b00) && (hdr_cur[15:8] == 8'h00);
         sid_in  = hdr_cur[37:22];
         ver_in  = hdr_cur[21:17];
         cn_in   = hdr_cur[16];
         sec_in  = hdr_cur[15:8];
         lsec_in = hdr_cur[7:0];
         crcw_in = crc_new;
      end

      if (qry_acc) begin
         busy_in = 1'b1;
      end else if (tok_chain[MAX_PROGRAMS].valid) begin
         busy_in = 1'b0;
         rv_in   = 1'b1;
         kind_in = KIND_QUERY;
         pid_in  = tok_chain[MAX_PROGRAMS].pid;
         pmt_in  = tok_chain[MAX_PROGRAMS].found;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         pos_ff   <= '0;
         len_ff   <= '0;
         hdr_ff   <= '0;
         ent_ff   <= '0;
         crc_ff   <= '0;
         cnt_ff   <= '0;
         nit_ff   <= NIT_PID_RESET;
         busy_ff  <= 1'b0;
         rv_ff    <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         len_ff   <= len_in;
         hdr_ff   <= hdr_in;
         ent_ff   <= ent_in;
         crc_ff   <= crc_in;
         cnt_ff   <= cnt_in;
         nit_ff   <= nit_in;
         busy_ff  <= busy_in;
         rv_ff    <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      prog_ff <= prog_in;
      pid_ff  <= pid_in;
      pmt_ff  <= pmt_in;
      rsn_ff  <= rsn_in;
      sv_ff   <= sv_in;
      sid_ff  <= sid_in;
      ver_ff  <= ver_in;
      cn_ff   <= cn_in;
      sec_ff  <= sec_in;
      lsec_ff <= lsec_in;
      crcw_ff <= crcw_in;
   end

   // lookup beat enters cell 0 carrying the entry count
   assign tok_chain[0] = '{valid: qry_acc, remaining: CNT_W'(cnt_ff),
                           pid: req_query_pid, found: 1'b0};

   genvar gi;
   generate
      for (gi = 0; gi < MAX_PROGRAMS; gi++) begin : g_cell
         logic [PID_W-1:0] pid_src;
         if (gi == 0) begin : g_head
            assign pid_src = new_pid;
         end else begin : g_link
            assign pid_src = pid_chain[gi-1];
         end
         tspat_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift_en (store),
            .pid_prev (pid_src),
            .pid_next (pid_chain[gi]),
            .tok_prev (tok_chain[gi]),
            .tok_next (tok_chain[gi+1])
         );
         assign tok_vld[gi] = tok_chain[gi+1].valid;
      end
   endgenerate

   assign busy                   = busy_ff;
   assign rsp_valid              = rv_ff;
   assign rsp_result_kind        = kind_ff;
   assign rsp_program_number     = prog_ff;
   assign rsp_pid                = pid_ff;
   assign rsp_is_pmt             = pmt_ff;
   assign rsp_reject_reason      = rsn_ff;
   assign rsp_section_valid      = sv_ff;
   assign rsp_stream_id          = sid_ff;
   assign rsp_version            = ver_ff;
   assign rsp_current_next       = cn_ff;
   assign rsp_section_index      = sec_ff;
   assign rsp_last_section_index = lsec_ff;
   assign rsp_crc_word           = crcw_ff;

   a_one_lookup: assert property (@(posedge clock) disable iff (reset)
      $onehot0(tok_vld))
      else $error("more than one lookup in the chain");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(MAX_PROGRAMS))
      else $error("entry count beyond capacity");

   a_lookup_busy: assert property (@(posedge clock) disable iff (reset)
      ($countones(tok_vld) != 0) |-> busy_ff)
      else $error("lookup in flight while not busy");

   a_query_rsp: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && kind_ff == KIND_QUERY) |-> $past(busy_ff))
      else $error("query answer without a lookup");

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (byte_acc && !req_start_of_section && phase_ff == PH_IDLE) |=> !rv_ff)
      else $error("result from a byte outside any section");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench
   import tspat_pkg::*;
();

   localparam int TBL_DEPTH   = 64;
   localparam int ITEM_TARGET = 1700;
   localparam int CALM_TAIL   = 200;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] prog;
      logic [12:0] pid;
      logic        pmt;
      logic [2:0]  reason;
      logic        sect_ok;
      logic [15:0] stream_id;
      logic [4:0]  ver;
      logic        cur_next;
      logic [7:0]  sec_num;
      logic [7:0]  last_sec;
      logic [31:0] crc;
   } pat_result_type;

   typedef struct packed {
      logic       act;
      logic [7:0] b;
      logic       sos;
      logic [12:0] qpid;
      logic       fixed;
      kind_type   fkind;
      logic [2:0] freason;
      logic       fpmt;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_action = 1'b0;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_start_of_section = 1'b0;
   logic [12:0] req_query_pid = 13'h0000;
   logic        rsp_valid;
   logic [1:0]  rsp_result_kind;
   logic [15:0] rsp_program_number;
   logic [12:0] rsp_pid;
   logic        rsp_is_pmt;
   logic [2:0]  rsp_reject_reason;
   logic        rsp_section_valid;
   logic [15:0] rsp_stream_id;
   logic [4:0]  rsp_version;
   logic        rsp_current_next;
   logic [7:0]  rsp_section_index;
   logic [7:0]  rsp_last_section_index;
   logic [31:0] rsp_crc_word;

   // predicted parser state
   phase_type   pred_phase = PH_IDLE;
   logic [11:0] byte_pos = '0;
   logic [11:0] sect_len = '0;
   logic [37:0] hdr_bits = '0;
   logic [31:0] entry_word = '0;
   logic [31:0] crc_acc = '0;
   logic [12:0] table_pid [TBL_DEPTH];
   int unsigned n_entries = 0;
   logic [12:0] nit_pid = NIT_PID_RESET;

   pat_result_type pending_results [$];
   int unsigned items_done = 0;
   int unsigned errors = 0;
   bit          idle_on = 1'b1;
   stim_row_type directed_rows [28];

   always #2 clock = ~clock;

   ts_pat_section_parser #(.MAX_PROGRAMS(TBL_DEPTH)) u_top (
      .clock                  (clock),
      .reset                  (reset),
      .start                  (start),
      .busy                   (busy),
      .req_action             (req_action),
      .req_data_byte          (req_data_byte),
      .req_start_of_section   (req_start_of_section),
      .req_query_pid          (req_query_pid),
      .rsp_valid              (rsp_valid),
      .rsp_result_kind        (rsp_result_kind),
      .rsp_program_number     (rsp_program_number),
      .rsp_pid                (rsp_pid),
      .rsp_is_pmt             (rsp_is_pmt),
      .rsp_reject_reason      (rsp_reject_reason),
      .rsp_section_valid      (rsp_section_valid),
      .rsp_stream_id          (rsp_stream_id),
      .rsp_version            (rsp_version),
      .rsp_current_next       (rsp_current_next),
      .rsp_section_index      (rsp_section_index),
      .rsp_last_section_index (rsp_last_section_index),
      .rsp_crc_word           (rsp_crc_word)
   );

   function automatic bit predict_pat_beat(input logic act, input logic [7:0] b,
                                           input logic sos, input logic [12:0] qpid,
                                           output pat_result_type r);
      logic [2:0]  rsn;
      int unsigned p, leff, n_ent, ent_end;
      r = '0;
      rsn = RSN_NONE;
      if (act) begin
         r.kind = KIND_QUERY;
         r.pid  = qpid;
         for (int i = 0; i < n_entries; i++)
            if (table_pid[i] == qpid) r.pmt = 1'b1;
         return 1'b1;
      end
      if (sos) begin
         pred_phase = PH_HEAD;
         byte_pos   = '0;
         sect_len   = '0;
         hdr_bits   = '0;
         entry_word = '0;
         crc_acc    = '0;
      end
      if (pred_phase == PH_HEAD) begin
         if (byte_pos == 0) begin
            if (b != PAT_TABLE_ID) rsn = RSN_TABLE_ID;
            else byte_pos = 12'd1;
         end else if (byte_pos == 1) begin
            if (!b[7]) rsn = RSN_SYNTAX;
            else if (b[6]) rsn = RSN_ZERO;
            else begin
               sect_len = {b[3:0], 8'h00};
               byte_pos = 12'd2;
            end
         end else begin
            sect_len[7:0] = b;
            byte_pos      = '0;
            pred_phase    = PH_BODY;
         end
         if (rsn != RSN_NONE) begin
            r.kind     = KIND_REJECT;
            r.reason   = rsn;
            pred_phase = PH_IDLE;
            return 1'b1;
         end
         return 1'b0;
      end
      if (pred_phase != PH_BODY) return 1'b0;

      p        = byte_pos;
      leff     = (sect_len < MIN_SECT_LEN) ? MIN_SECT_LEN : sect_len;
      n_ent    = (leff - 9) / 4;
      ent_end  = 5 + 4 * n_ent;
      byte_pos = byte_pos + 12'd1;
      if (p < 5) begin
         // third header byte keeps only the version/current bits
         if (p == 2) hdr_bits = {hdr_bits[31:0], b[5:0]};
         else hdr_bits = {hdr_bits[29:0], b};
         return 1'b0;
      end
      if (p < ent_end) begin
         entry_word = {entry_word[23:0], b};
         if (((p - 5) & 3) == 3) begin
            r.kind = KIND_ENTRY;
            r.prog = entry_word[31:16];
            r.pid  = entry_word[12:0];
            if (n_entries < TBL_DEPTH) begin
               table_pid[n_entries] = entry_word[12:0];
               n_entries++;
            end else begin
               r.reason = RSN_FULL;
            end
            if (entry_word[31:16] == 16'h0000) nit_pid = entry_word[12:0];
            return 1'b1;
         end
         return 1'b0;
      end
      if (p >= leff - 4) begin
         crc_acc = {crc_acc[23:0], b};
         if (p == leff - 1) begin
            r.kind      = KIND_DONE;
            r.pid       = nit_pid;
            r.sect_ok   = (sect_len[11:10] == 2'b00) && (hdr_bits[15:8] == 8'h00);
            r.stream_id = hdr_bits[37:22];
            r.ver       = hdr_bits[21:17];
            r.cur_next  = hdr_bits[16];
            r.sec_num   = hdr_bits[15:8];
            r.last_sec  = hdr_bits[7:0];
            r.crc       = crc_acc;
            pred_phase  = PH_IDLE;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic void check_field(input string fname, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", fname, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      pat_result_type want_res;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_results.size() == 0) begin
            $error("result with nothing pending, kind %0d", rsp_result_kind);
            errors++;
         end else begin
            want_res = pending_results.pop_front();
            check_field("result_kind", want_res.kind, rsp_result_kind);
            check_field("program_number", want_res.prog, rsp_program_number);
            check_field("pid", want_res.pid, rsp_pid);
            check_field("is_pmt", want_res.pmt, rsp_is_pmt);
            check_field("reject_reason", want_res.reason, rsp_reject_reason);
            check_field("section_valid", want_res.sect_ok, rsp_section_valid);
            check_field("stream_id", want_res.stream_id, rsp_stream_id);
            check_field("version", want_res.ver, rsp_version);
            check_field("current_next", want_res.cur_next, rsp_current_next);
            check_field("section_index", want_res.sec_num, rsp_section_index);
            check_field("last_section_index", want_res.last_sec, rsp_last_section_index);
            check_field("crc_word", want_res.crc, rsp_crc_word);
         end
      end
   end

   task automatic send_beat(input logic act, input logic [7:0] b, input logic sos,
                            input logic [12:0] qpid, input bit use_fixed,
                            input pat_result_type fixed_res);
      pat_result_type r;
      bit          has_res;
      bit          ignored;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_action           <= act;
      req_data_byte        <= b;
      req_start_of_section <= sos;
      req_query_pid        <= qpid;
      start                <= 1'b1;
      do @(posedge clock); while (busy);
      ignored = !act && !sos && pred_phase == PH_IDLE;
      has_res = predict_pat_beat(act, b, sos, qpid, r);
      if (use_fixed) pending_results.insert(pending_results.size(), fixed_res);
      else if (has_res) pending_results.insert(pending_results.size(), r);
      if (!ignored) items_done++;
      if (items_done > ITEM_TARGET - CALM_TAIL) idle_on = 1'b0;
   endtask

   // hold the sender until every pending result has shown up
   task automatic drain_results();
      start <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   // one section byte, sometimes preceded by a lookup beat
   task automatic feed_byte(input logic [7:0] b, input logic sos);
      logic [12:0] q;
      if ($urandom_range(0, 15) == 0) begin
         q = 13'($urandom);
         if (n_entries != 0 && $urandom_range(0, 1) == 1)
            q = table_pid[$urandom_range(0, n_entries - 1)];
         send_beat(1'b1, 8'($urandom), 1'($urandom), q, 1'b0, '0);
      end
      send_beat(1'b0, b, sos, 13'h0000, 1'b0, '0);
   endtask

   task automatic send_section(input bit long_one);
      logic [7:0]  body [$];
      logic [15:0] len_word;
      logic [15:0] prog;
      logic [7:0]  hb;
      int unsigned mode, len, leff, n_ent, cut;
      mode = $urandom_range(0, 15);
      body.insert(body.size(), mode == 0 ? 8'($urandom_range(1, 255)) : PAT_TABLE_ID);
      if (long_one)
         len = 12'h400 + $urandom_range(0, 15);
      else if ($urandom_range(0, 9) == 0)
         len = $urandom_range(0, 8);
      else
         len = 9 + 4 * $urandom_range(0, 4) + $urandom_range(0, 3);
      leff = (len < 9) ? 9 : len;
      len_word = {1'b1, 1'b0, 2'($urandom_range(0, 3)), 12'(len)};
      if (mode == 1) len_word[15] = 1'b0;
      if (mode == 2) len_word[14] = 1'b1;
      body.insert(body.size(), len_word[15:8]);
      body.insert(body.size(), len_word[7:0]);
      for (int i = 0; i < 5; i++) begin
         hb = 8'($urandom);
         if (i == 3 && $urandom_range(0, 2) != 0) hb = 8'h00;
         body.insert(body.size(), hb);
      end
      n_ent = (leff - 9) / 4;
      for (int i = 0; i < n_ent; i++) begin
         prog = ($urandom_range(0, 9) == 0) ? 16'h0000 : 16'($urandom);
         body.insert(body.size(), prog[15:8]);
         body.insert(body.size(), prog[7:0]);
         body.insert(body.size(), 8'($urandom));
         body.insert(body.size(), 8'($urandom));
      end
      for (int i = 0; i < leff - 9 - 4 * n_ent + 4; i++)
         body.insert(body.size(), 8'($urandom));
      cut = body.size();
      if ($urandom_range(0, 9) == 0) cut = $urandom_range(1, body.size() - 1);
      for (int i = 0; i < cut; i++) feed_byte(body[i], i == 0);
      // stray bytes between sections
      if ($urandom_range(0, 4) == 0)
         repeat ($urandom_range(1, 3)) feed_byte(8'($urandom), 1'b0);
   endtask

   initial begin
      stim_row_type   row;
      pat_result_type fixed_res;
      int unsigned sect_no, long_at;
      bit          paused;
      directed_rows = '{
         '{1'b1, 8'h00, 1'b0, 13'h1FFF, 1'b1, KIND_QUERY,  RSN_NONE,     1'b0},
         '{1'b0, 8'hFF, 1'b0, 13'h0000, 1'b0, KIND_ENTRY,  RSN_NONE,     1'b0},
         '{1'b0, 8'hFF, 1'b1, 13'h0000, 1'b1, KIND_REJECT, RSN_TABLE_ID, 1'b0},
         '{1'b0, 8'h00, 1'b1, 13'h0000, 1'b0, KIND_ENTRY,  RSN_NONE,     1'b0},
         '{1'b0, 8'h7F, 1'b0, 13'h0000, 1'b1, KIND_REJECT, RSN_SYNTAX,   1'b0},
         '{1'b0, 8'h00, 1'b1, 13'h0000, 1'b0, KIND_ENTRY,  RSN_NONE,     1'b0},
         '{1'b0, 8'hC0, 1'b0, 13'h0000, 1'b1, KIND_REJECT, RSN_ZERO,     1'b0},
         '{1'b0, 8'h00, 1'b1, 13'h0000, 1'b0, KIND_ENTRY,  RSN_NONE,     1'b0},
         '{1'b0, 8'h80, 1'b0, 13'h0000, 1'b0, KIND_ENTRY,  RSN_NONE,     1'b0},
         '{1'b1, 8'hFF, 1'b1, 13'h0000, 1'b1, KIND_QUERY,  RSN_NONE,     1'b0},
         '{1'b0, 8'h0F, 1'b0, 13'h0000, 1'b0, KIND_ENTRY,  RSN_NONE,     1'b0},
         '{1'b0, 8'hFF, 1'b0, 13'h0000, 1'b0, KIND_ENTRY,  RSN_NONE,     1'b0},
         '{1'b0, 8'hFF, 1'b0, 13'h0000, 1'b0, KIND_ENTRY,  RSN_NONE,     1'b0},
         '{1'b0, 8'hFF, 1'b0, 13'h0000, 1'b0, KIND_ENTRY,  RSN_NONE,     1'b0},
         '{1'b0, 8'h00, 1'b0, 13'h0000, 1'b0, KIND_ENTRY,  RSN_NONE,     1'b0},
         '{1'b0, 8'hFF, 1'b0, 13'h0000, 1'b0, KIND_ENTRY,  RSN_NONE,     1'b0},
         '{1'b0, 8'h00, 1'b0, 13'h0000, 1'b0, KIND_ENTRY,  RSN_NONE,     1'b0},
         '{1'b0, 8'h00, 1'b0, 13'h0000, 1'b0, KIND_ENTRY,  RSN_NONE,     1'b0},
         '{1'b0, 8'hFF, 1'b0, 13'h0000, 1'b0, KIND_ENTRY,  RSN_NONE,     1'b0},
         '{1'b0, 8'hFF, 1'b0, 13'h0000, 1'b0, KIND_ENTRY,  RSN_NONE,     1'b0},
         '{1'b0, 8'hAA, 1'b0, 13'h0000, 1'b0, KIND_ENTRY,  RSN_NONE,     1'b0},
         '{1'b0, 8'h55, 1'b0, 13'h0000, 1'b0, KIND_ENTRY,  RSN_NONE,     1'b0},
         '{1'b0, 8'hDE, 1'b0, 13'h0000, 1'b0, KIND_ENTRY,  RSN_NONE,     1'b0},
         '{1'b0, 8'hAD, 1'b0, 13'h0000, 1'b0, KIND_ENTRY,  RSN_NONE,     1'b0},
         '{1'b0, 8'hBE, 1'b0, 13'h0000, 1'b0, KIND_ENTRY,  RSN_NONE,     1'b0},
         '{1'b0, 8'hEF, 1'b0, 13'h0000, 1'b0, KIND_ENTRY,  RSN_NONE,     1'b0},
         '{1'b1, 8'h00, 1'b0, 13'h1FFF, 1'b0, KIND_ENTRY,  RSN_NONE,     1'b0},
         '{1'b0, 8'h00, 1'b1, 13'h0000, 1'b0, KIND_ENTRY,  RSN_NONE,     1'b0}
      };
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // rejects, a lookup mid-header, a full section with one entry and remainder
      // bytes, a lookup, then a section left open so the random part restarts it
      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         fixed_res        = '0;
         fixed_res.kind   = row.fkind;
         fixed_res.reason = row.freason;
         fixed_res.pmt    = row.fpmt;
         if (row.fkind == KIND_QUERY) fixed_res.pid = row.qpid;
         send_beat(row.act, row.b, row.sos, row.qpid, row.fixed, fixed_res);
      end
      drain_results();

      sect_no = 0;
      long_at = $urandom_range(3, 30);
      paused  = 1'b0;
      while (items_done < ITEM_TARGET) begin
         send_section(sect_no == long_at);
         sect_no++;
         if (!paused && items_done > ITEM_TARGET / 2) begin
            drain_results();
            paused = 1'b1;
         end
      end

      drain_results();
      repeat (TBL_DEPTH + 8) @(posedge clock);
      if (errors == 0) begin
         $display("ts_pat_section_parser: match");
      end else begin
         $display("ts_pat_section_parser: mismatch");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("ts_pat_section_parser: mismatch");
      $finish;
   end

endmodule
